### hw/rtl/g2g_pkg.sv
// ----------------------------------------------------------------------------
// g2g_pkg: shared definitions for the go-to-goal steering controller
// Codes, widths, fixed-point constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package g2g_pkg;

   // Number of CORDIC vectoring iterations (valid range 8 to 24).
   localparam int CORDIC_ITERATIONS = 16;
   localparam int CNT_W = $clog2(CORDIC_ITERATIONS);

   // Vector input to the CORDIC: a difference of two Q16.16 values.
   localparam int VEC_W = 34;
   // Internal CORDIC datapath: input scaled by 256 plus growth headroom.
   localparam int CX_W = 46;
   // Magnitude as produced by the CORDIC (before the 1/K correction).
   localparam int MAG_W = 44;
   // Angles in Q3.28.
   localparam int ANG_W = 32;

   localparam logic signed [ANG_W-1:0] HALF_PI_Q28 = 32'sd421657428;
   localparam logic signed [17:0] PI_Q13 = 18'sd25736;
   localparam logic signed [17:0] TWO_PI_Q13 = 18'sd51472;
   localparam logic [19:0] INV_K_Q20 = 20'd636751;

   typedef enum logic [1:0] {
      OP_POSE = 2'd0,
      OP_TARGET = 2'd1,
      OP_TICK = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      STATUS_IDLE = 2'd0,
      STATUS_APPROACH = 2'd1,
      STATUS_ARRIVED = 2'd2
   } status_type;

   localparam logic [2:0] CSR_LINEAR_GAIN = 3'd0;
   localparam logic [2:0] CSR_ANGULAR_GAIN = 3'd1;
   localparam logic [2:0] CSR_MAX_LINEAR = 3'd2;
   localparam logic [2:0] CSR_MAX_ANGULAR = 3'd3;
   localparam logic [2:0] CSR_PICKUP = 3'd4;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_Q0, ST_Q1, ST_Q2, ST_Q3, ST_Q4,
      ST_YAW_GO, ST_YAW_RUN,
      ST_BRG_GO, ST_BRG_RUN,
      ST_D0, ST_D1, ST_D2, ST_D3,
      ST_CMP,
      ST_L0, ST_L1, ST_L2, ST_L3,
      ST_A0,
      ST_DONE
   } state_type;

   // Arctangent of 2^-i in Q3.28.
   function automatic logic signed [ANG_W-1:0] atan_q28(input logic [4:0] idx);
      logic signed [ANG_W-1:0] r;
      case (idx)
         5'd0: r = 32'sd210828714;
         5'd1: r = 32'sd124459457;
         5'd2: r = 32'sd65760959;
         5'd3: r = 32'sd33381290;
         5'd4: r = 32'sd16755422;
         5'd5: r = 32'sd8385879;
         5'd6: r = 32'sd4193963;
         5'd7: r = 32'sd2097109;
         5'd8: r = 32'sd1048571;
         5'd9: r = 32'sd524287;
         5'd10: r = 32'sd262144;
         5'd11: r = 32'sd131072;
         5'd12: r = 32'sd65536;
         5'd13: r = 32'sd32768;
         5'd14: r = 32'sd16384;
         5'd15: r = 32'sd8192;
         5'd16: r = 32'sd4096;
         5'd17: r = 32'sd2048;
         5'd18: r = 32'sd1024;
         5'd19: r = 32'sd512;
         5'd20: r = 32'sd256;
         5'd21: r = 32'sd128;
         5'd22: r = 32'sd64;
         5'd23: r = 32'sd32;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/g2g_cordic.sv
// ----------------------------------------------------------------------------
// g2g_cordic: iterative CORDIC vectoring unit
// Returns atan2(y, x) in Q3.28 and the unscaled magnitude, one step a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module g2g_cordic
   import g2g_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic signed [VEC_W-1:0] vec_x,
   input  wire logic signed [VEC_W-1:0] vec_y,
   output logic                         done,
   output logic signed [ANG_W-1:0]      angle,
   output logic [MAG_W-1:0]             magnitude
);

   logic signed [CX_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [ANG_W-1:0] z_ff, z_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic signed [CX_W-1:0] sx, sy, xs, ys;

   always_comb begin
      sx = CX_W'(vec_x) <<< 8;
      sy = CX_W'(vec_y) <<< 8;
      xs = x_ff >>> cnt_ff;
      ys = y_ff >>> cnt_ff;
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         cnt_in = '0;
         if (vec_x == '0 && vec_y == '0) begin
            // The zero vector has angle and magnitude zero.
            x_in = '0;
            y_in = '0;
            z_in = '0;
            done_in = 1'b1;
            busy_in = 1'b0;
         end else begin
            busy_in = 1'b1;
            if (sx < 0) begin
               if (sy >= 0) begin
                  x_in = sy;
                  y_in = -sx;
                  z_in = HALF_PI_Q28;
               end else begin
                  x_in = -sy;
                  y_in = sx;
                  z_in = -HALF_PI_Q28;
               end
            end else begin
               x_in = sx;
               y_in = sy;
               z_in = '0;
            end
         end
      end else if (busy_ff) begin
         if (y_ff > 0) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + atan_q28(5'(cnt_ff));
         end else begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - atan_q28(5'(cnt_ff));
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(CORDIC_ITERATIONS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign done = done_ff;
   assign angle = z_ff;
   assign magnitude = x_ff[MAG_W-1:0];

endmodule

`default_nettype wire

### hw/rtl/go_to_goal_steering_controller_core.sv
// ----------------------------------------------------------------------------
// go_to_goal_steering_controller_core: proportional go-to-goal controller
// Holds pose and target, and on each control tick issues speed commands.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Carries
// req_*     in         req_valid / req_stall  pose update, target update, tick
// rsp_*     out        rsp_valid / rsp_stall  linear, angular command, status
// csr_*     in         csr_wr_en              gain, clamp and radius registers
//
// A control tick with both a pose and a target held makes two passes through
// the one CORDIC unit and steps on the shared 25x25 multiplier. Reset is
// synchronous and active high; it clears the held pose and target and loads
// the register defaults. A stalled response is held in the output register
// while new requests are still taken.
// ----------------------------------------------------------------------------
`default_nettype none

module go_to_goal_steering_controller_core
   import g2g_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_operation,
   input  wire logic signed [31:0] req_point_x,
   input  wire logic signed [31:0] req_point_y,
   input  wire logic signed [15:0] req_orient_x,
   input  wire logic signed [15:0] req_orient_y,
   input  wire logic signed [15:0] req_orient_z,
   input  wire logic signed [15:0] req_orient_w,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [14:0]             rsp_linear_command,
   output logic signed [15:0]      rsp_angular_command,
   output logic [1:0]              rsp_motion_status,
   input  wire logic               csr_wr_en,
   input  wire logic [2:0]         csr_index,
   input  wire logic [30:0]        csr_wr_data
);

   // Configuration registers.
   logic [15:0] lin_gain_ff, ang_gain_ff;
   logic [14:0] max_lin_ff, max_ang_ff;
   logic [30:0] pickup_ff;

   // Held pose and target.
   logic pose_valid_ff, target_valid_ff, target_valid_in;
   logic signed [31:0] pose_x_ff, pose_y_ff, target_x_ff, target_y_ff;
   logic signed [15:0] qx_ff, qy_ff, qz_ff, qw_ff;

   // Sequencer and datapath registers.
   state_type state_ff, state_in;
   logic signed [49:0] prod_ff, prod_in;
   logic signed [65:0] acc_ff, acc_in;
   logic signed [31:0] siny_ff, siny_in;
   logic signed [17:0] yaw_ff, yaw_in, brg_ff, brg_in, err_ff, err_in;
   logic [MAG_W-1:0] mag_ff, mag_in;
   logic [34:0] dist_ff, dist_in;
   logic [34:0] diff_ff, diff_in;
   logic [14:0] res_lin_ff, res_lin_in;
   logic signed [15:0] res_ang_ff, res_ang_in;
   logic [1:0] res_stat_ff, res_stat_in;

   // Output register.
   logic rsp_valid_ff, rsp_valid_in;
   logic [14:0] rsp_lin_ff, rsp_lin_in;
   logic signed [15:0] rsp_ang_ff, rsp_ang_in;
   logic [1:0] rsp_stat_ff, rsp_stat_in;

   // Shared multiplier operands.
   logic signed [24:0] mul_a, mul_b;

   // CORDIC hookup.
   logic cor_start, cor_done;
   logic signed [VEC_W-1:0] cor_x, cor_y;
   logic signed [ANG_W-1:0] cor_angle;
   logic [MAG_W-1:0] cor_mag;

   logic req_take;
   logic signed [VEC_W-1:0] dx, dy;
   logic signed [65:0] cos_full, rnd;
   logic signed [17:0] ang_q13, err_raw;
   logic [16:0] err_abs;
   logic [34:0] lin_full;
   logic [19:0] amag_full;
   logic [14:0] amag;

   g2g_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .start     (cor_start),
      .vec_x     (cor_x),
      .vec_y     (cor_y),
      .done      (cor_done),
      .angle     (cor_angle),
      .magnitude (cor_mag)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take = req_valid && !req_stall;

   assign dx = VEC_W'(target_x_ff) - VEC_W'(pose_x_ff);
   assign dy = VEC_W'(target_y_ff) - VEC_W'(pose_y_ff);
   assign err_abs = err_ff[17] ? 17'(-err_ff) : 17'(err_ff);

   always_comb begin
      state_in = state_ff;
      prod_in = prod_ff;
      acc_in = acc_ff;
      siny_in = siny_ff;
      yaw_in = yaw_ff;
      brg_in = brg_ff;
      err_in = err_ff;
      mag_in = mag_ff;
      dist_in = dist_ff;
      diff_in = diff_ff;
      res_lin_in = res_lin_ff;
      res_ang_in = res_ang_ff;
      res_stat_in = res_stat_ff;
      target_valid_in = target_valid_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_lin_in = rsp_lin_ff;
      rsp_ang_in = rsp_ang_ff;
      rsp_stat_in = rsp_stat_ff;
      mul_a = '0;
      mul_b = '0;
      cor_start = 1'b0;
      cor_x = dx;
      cor_y = dy;
      cos_full = 66'sd268435456 - (acc_ff <<< 1);
      rnd = '0;
      ang_q13 = 18'((cor_angle + 32'sd16384) >>> 15);
      err_raw = brg_ff - yaw_ff;
      lin_full = '0;
      amag_full = '0;
      amag = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_take && req_operation == OP_TARGET) begin
               target_valid_in = 1'b1;
            end
            if (req_take && req_operation == OP_TICK) begin
               if (pose_valid_ff && target_valid_ff) begin
                  state_in = ST_Q0;
               end else begin
                  res_lin_in = '0;
                  res_ang_in = '0;
                  res_stat_in = STATUS_IDLE;
                  state_in = ST_DONE;
               end
            end
         end
         // Yaw terms: siny = 2(wz + xy), cosy = 1 - 2(yy + zz).
         ST_Q0: begin
            mul_a = 25'(qw_ff);
            mul_b = 25'(qz_ff);
            state_in = ST_Q1;
         end
         ST_Q1: begin
            mul_a = 25'(qx_ff);
            mul_b = 25'(qy_ff);
            acc_in = 66'(prod_ff);
            state_in = ST_Q2;
         end
         ST_Q2: begin
            mul_a = 25'(qy_ff);
            mul_b = 25'(qy_ff);
            acc_in = acc_ff + 66'(prod_ff);
            state_in = ST_Q3;
         end
         ST_Q3: begin
            mul_a = 25'(qz_ff);
            mul_b = 25'(qz_ff);
            siny_in = {acc_ff[30:0], 1'b0};
            acc_in = 66'(prod_ff);
            state_in = ST_Q4;
         end
         ST_Q4: begin
            acc_in = acc_ff + 66'(prod_ff);
            state_in = ST_YAW_GO;
         end
         ST_YAW_GO: begin
            cor_x = cos_full[VEC_W-1:0];
            cor_y = VEC_W'(siny_ff);
            cor_start = 1'b1;
            state_in = ST_YAW_RUN;
         end
         ST_YAW_RUN: begin
            if (cor_done) begin
               yaw_in = ang_q13;
               state_in = ST_BRG_GO;
            end
         end
         ST_BRG_GO: begin
            cor_start = 1'b1;
            state_in = ST_BRG_RUN;
         end
         ST_BRG_RUN: begin
            if (cor_done) begin
               brg_in = ang_q13;
               mag_in = cor_mag;
               state_in = ST_D0;
            end
         end
         // Distance = magnitude / K, in two partial products.
         ST_D0: begin
            mul_a = 25'({1'b0, mag_ff[21:0]});
            mul_b = 25'({1'b0, INV_K_Q20});
            state_in = ST_D1;
         end
         ST_D1: begin
            mul_a = 25'({1'b0, mag_ff[MAG_W-1:22]});
            mul_b = 25'({1'b0, INV_K_Q20});
            acc_in = 66'(prod_ff);
            state_in = ST_D2;
         end
         ST_D2: begin
            acc_in = acc_ff + (66'(prod_ff) <<< 22);
            state_in = ST_D3;
         end
         ST_D3: begin
            rnd = acc_ff + 66'sd134217728;
            dist_in = rnd[62:28];
            // Heading error, wrapped into plus or minus pi.
            if (err_raw > PI_Q13) begin
               err_in = err_raw - TWO_PI_Q13;
            end else if (err_raw < -PI_Q13) begin
               err_in = err_raw + TWO_PI_Q13;
            end else begin
               err_in = err_raw;
            end
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (dist_ff <= 35'(pickup_ff)) begin
               target_valid_in = 1'b0;
               res_lin_in = '0;
               res_ang_in = '0;
               res_stat_in = STATUS_ARRIVED;
               state_in = ST_DONE;
            end else begin
               diff_in = dist_ff - 35'(pickup_ff);
               state_in = ST_L0;
            end
         end
         ST_L0: begin
            mul_a = 25'({1'b0, diff_ff[21:0]});
            mul_b = 25'({1'b0, lin_gain_ff});
            state_in = ST_L1;
         end
         ST_L1: begin
            mul_a = 25'({1'b0, diff_ff[34:22]});
            mul_b = 25'({1'b0, lin_gain_ff});
            acc_in = 66'(prod_ff);
            state_in = ST_L2;
         end
         ST_L2: begin
            acc_in = acc_ff + (66'(prod_ff) <<< 22);
            state_in = ST_L3;
         end
         ST_L3: begin
            rnd = acc_ff + 66'sd32768;
            lin_full = rnd[50:16];
            res_lin_in = (lin_full > 35'(max_lin_ff)) ? max_lin_ff : lin_full[14:0];
            mul_a = 25'({1'b0, err_abs});
            mul_b = 25'({1'b0, ang_gain_ff});
            state_in = ST_A0;
         end
         ST_A0: begin
            rnd = 66'(prod_ff) + 66'sd4096;
            amag_full = rnd[32:13];
            amag = (amag_full > 20'(max_ang_ff)) ? max_ang_ff : amag_full[14:0];
            res_ang_in = err_ff[17] ? -16'(amag) : 16'(amag);
            res_stat_in = STATUS_APPROACH;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // Wait until the output register is free or being emptied.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_lin_in = res_lin_ff;
               rsp_ang_in = res_ang_ff;
               rsp_stat_in = res_stat_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pose_valid_ff <= 1'b0;
         target_valid_ff <= 1'b0;
         pose_x_ff <= '0;
         pose_y_ff <= '0;
         target_x_ff <= '0;
         target_y_ff <= '0;
         qx_ff <= '0;
         qy_ff <= '0;
         qz_ff <= '0;
         qw_ff <= '0;
         lin_gain_ff <= 16'd2253;
         ang_gain_ff <= 16'd7373;
         max_lin_ff <= 15'd1434;
         max_ang_ff <= 15'd3686;
         pickup_ff <= 31'd29491;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         target_valid_ff <= target_valid_in;
         if (req_take && req_operation == OP_POSE) begin
            pose_valid_ff <= 1'b1;
            pose_x_ff <= req_point_x;
            pose_y_ff <= req_point_y;
            qx_ff <= req_orient_x;
            qy_ff <= req_orient_y;
            qz_ff <= req_orient_z;
            qw_ff <= req_orient_w;
         end
         if (req_take && req_operation == OP_TARGET) begin
            target_x_ff <= req_point_x;
            target_y_ff <= req_point_y;
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_LINEAR_GAIN: lin_gain_ff <= csr_wr_data[15:0];
               CSR_ANGULAR_GAIN: ang_gain_ff <= csr_wr_data[15:0];
               CSR_MAX_LINEAR: max_lin_ff <= csr_wr_data[14:0];
               CSR_MAX_ANGULAR: max_ang_ff <= csr_wr_data[14:0];
               CSR_PICKUP: pickup_ff <= csr_wr_data;
               default: begin
               end
            endcase
         end
      end
      prod_ff <= prod_in;
      acc_ff <= acc_in;
      siny_ff <= siny_in;
      yaw_ff <= yaw_in;
      brg_ff <= brg_in;
      err_ff <= err_in;
      mag_ff <= mag_in;
      dist_ff <= dist_in;
      diff_ff <= diff_in;
      res_lin_ff <= res_lin_in;
      res_ang_ff <= res_ang_in;
      res_stat_ff <= res_stat_in;
      rsp_lin_ff <= rsp_lin_in;
      rsp_ang_ff <= rsp_ang_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_linear_command = rsp_lin_ff;
   assign rsp_angular_command = rsp_ang_ff;
   assign rsp_motion_status = rsp_stat_ff;

`ifndef SYNTHESIS
   // The CORDIC only finishes while the sequencer is waiting on it.
   a_cordic_done: assert property (@(posedge clock) disable iff (reset)
      cor_done |-> (state_ff == ST_YAW_RUN || state_ff == ST_BRG_RUN))
      else $error("CORDIC finished outside a wait state");

   // Idle and arrived responses carry zero commands.
   a_zero_cmd: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_motion_status != STATUS_APPROACH)
         |-> (rsp_linear_command == '0 && rsp_angular_command == '0))
      else $error("nonzero command without approach status");

   // Forward speed never exceeds its clamp.
   a_lin_clamp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_motion_status == STATUS_APPROACH)
         |-> (rsp_linear_command <= max_lin_ff))
      else $error("linear command above clamp");
`endif

endmodule

`default_nettype wire
